// ===== src/assert_macros.svh =====
// Assertion macros shared by the particle step RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LEP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lep_pkg.sv =====
// Shared types, constants and the step table of the particle push block.
// No dependencies; used by every other file of the block but assert_macros.svh.
package lep_pkg;

   localparam int DEFAULT_WORD_WIDTH = 40;
   localparam int DEFAULT_FRAC_BITS  = 24;
   localparam int TIME_STEP_WIDTH    = 24;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int DIGIT_WIDTH        = 8;

   // Reset time step is one thousandth, reset z velocity is ten.
   localparam longint unsigned STEP_DIVISOR   = 64'd1000;
   localparam longint unsigned START_VZ_SCALE = 64'd10;

   localparam int STEP_WIDTH = 4;
   localparam int NUM_STEPS  = 15;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUM_STEPS - 1);

   typedef logic [1:0] lane_type;
   localparam lane_type LANE_X = 2'd0;
   localparam lane_type LANE_Y = 2'd1;
   localparam lane_type LANE_Z = 2'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TIME_STEP,
      CSR_CHARGE_TO_MASS,
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z,
      CSR_START_VX,
      CSR_START_VY,
      CSR_START_VZ
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FINISH
   } lep_state_type;

   typedef enum logic [1:0] {
      A_VEL,
      A_QM,
      A_ACC
   } a_src_type;

   typedef enum logic [1:0] {
      B_FIELD,
      B_ACC,
      B_DT
   } b_src_type;

   typedef enum logic [2:0] {
      POST_TMP,
      POST_SUB_ACC,
      POST_MOV_ACC,
      POST_ADD_POS,
      POST_ADD_VEL
   } post_type;

   typedef struct packed {
      a_src_type a_src;
      lane_type  a_idx;
      b_src_type b_src;
      lane_type  b_idx;
      post_type  post;
      lane_type  dst;
   } uop_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } mul_status_type;

   function automatic uop_type make_uop(a_src_type a_src, lane_type a_idx, b_src_type b_src,
                                        lane_type b_idx, post_type post, lane_type dst);
      uop_type u;
      u.a_src = a_src;
      u.a_idx = a_idx;
      u.b_src = b_src;
      u.b_idx = b_idx;
      u.post  = post;
      u.dst   = dst;
      return u;
   endfunction

   // One multiplication per step: cross product, charge scaling, then the
   // position and velocity updates.
   function automatic uop_type decode_step(logic [STEP_WIDTH-1:0] step);
      uop_type u;
      case (step)
         4'd0:    u = make_uop(A_VEL, LANE_Y, B_FIELD, LANE_Z, POST_TMP,     LANE_X);
         4'd1:    u = make_uop(A_VEL, LANE_Z, B_FIELD, LANE_Y, POST_SUB_ACC, LANE_X);
         4'd2:    u = make_uop(A_QM,  LANE_X, B_ACC,   LANE_X, POST_MOV_ACC, LANE_X);
         4'd3:    u = make_uop(A_VEL, LANE_Z, B_FIELD, LANE_X, POST_TMP,     LANE_Y);
         4'd4:    u = make_uop(A_VEL, LANE_X, B_FIELD, LANE_Z, POST_SUB_ACC, LANE_Y);
         4'd5:    u = make_uop(A_QM,  LANE_X, B_ACC,   LANE_Y, POST_MOV_ACC, LANE_Y);
         4'd6:    u = make_uop(A_VEL, LANE_X, B_FIELD, LANE_Y, POST_TMP,     LANE_Z);
         4'd7:    u = make_uop(A_VEL, LANE_Y, B_FIELD, LANE_X, POST_SUB_ACC, LANE_Z);
         4'd8:    u = make_uop(A_QM,  LANE_X, B_ACC,   LANE_Z, POST_MOV_ACC, LANE_Z);
         4'd9:    u = make_uop(A_VEL, LANE_X, B_DT,    LANE_X, POST_ADD_POS, LANE_X);
         4'd10:   u = make_uop(A_VEL, LANE_Y, B_DT,    LANE_X, POST_ADD_POS, LANE_Y);
         4'd11:   u = make_uop(A_VEL, LANE_Z, B_DT,    LANE_X, POST_ADD_POS, LANE_Z);
         4'd12:   u = make_uop(A_ACC, LANE_X, B_DT,    LANE_X, POST_ADD_VEL, LANE_X);
         4'd13:   u = make_uop(A_ACC, LANE_Y, B_DT,    LANE_X, POST_ADD_VEL, LANE_Y);
         4'd14:   u = make_uop(A_ACC, LANE_Z, B_DT,    LANE_X, POST_ADD_VEL, LANE_Z);
         default: u = make_uop(A_VEL, LANE_X, B_DT,    LANE_X, POST_TMP,     LANE_X);
      endcase
      return u;
   endfunction

   // Reset value of a configuration register, before truncation to its width.
   function automatic logic [63:0] csr_reset_value(csr_index_type idx, int frac_bits);
      logic [63:0] one;
      logic [63:0] value;
      one = 64'd1 << frac_bits;
      case (idx)
         CSR_TIME_STEP:      value = one / STEP_DIVISOR;
         CSR_CHARGE_TO_MASS: value = one;
         CSR_START_Y:        value = one;
         CSR_START_VX:       value = one;
         CSR_START_VZ:       value = START_VZ_SCALE * one;
         default:            value = 64'd0;
      endcase
      return value;
   endfunction

endpackage

// ===== src/lep_if.sv =====
// Channel interfaces of the particle push block: step requests, step
// responses and configuration writes. Depends on lep_pkg.
interface lep_req_if #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic                         restart;
   logic signed [WORD_WIDTH-1:0] field_x;
   logic signed [WORD_WIDTH-1:0] field_y;
   logic signed [WORD_WIDTH-1:0] field_z;

   modport source (output valid, output restart, output field_x, output field_y,
                   output field_z, input ready);
   modport sink   (input valid, input restart, input field_x, input field_y,
                   input field_z, output ready);
endinterface

interface lep_rsp_if #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] pos_x;
   logic signed [WORD_WIDTH-1:0] pos_y;
   logic signed [WORD_WIDTH-1:0] pos_z;
   logic signed [WORD_WIDTH-1:0] vel_x;
   logic signed [WORD_WIDTH-1:0] vel_y;
   logic signed [WORD_WIDTH-1:0] vel_z;
   logic                         saturated;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output vel_x,
                   output vel_y, output vel_z, output saturated, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, input vel_x,
                   input vel_y, input vel_z, input saturated, output ready);
endinterface

interface lep_csr_if #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH
);
   logic                                  valid;
   logic                                  ready;
   logic [lep_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [WORD_WIDTH-1:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lep_serial_mul.sv =====
// Digit-serial signed fixed-point multiplier with floor shift and saturation.
// Depends on lep_pkg (digit width, status struct).
module lep_serial_mul #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH,
   parameter int FRAC_BITS  = lep_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [WORD_WIDTH:0]   op_a,
   input  logic signed [WORD_WIDTH:0]   op_b,
   output logic signed [WORD_WIDTH-1:0] result,
   output lep_pkg::mul_status_type      status
);

   localparam int DigW   = lep_pkg::DIGIT_WIDTH;
   localparam int OpW    = WORD_WIDTH + 1;
   localparam int NumDig = (OpW + DigW - 1) / DigW;
   localparam int BW     = NumDig * DigW;
   localparam int SumW   = OpW + DigW + 1;
   localparam int ProdW  = OpW + 1 + BW;
   localparam int NeedW  = FRAC_BITS + WORD_WIDTH + 1;
   localparam int ExtW   = (ProdW > NeedW) ? ProdW : NeedW;
   localparam int TopW   = ExtW - (FRAC_BITS + WORD_WIDTH - 1);
   localparam int CntW   = $clog2(NumDig + 1);

   logic signed [OpW-1:0]  a_ff, a_in;
   logic [BW-1:0]          b_ff, b_in;
   logic signed [OpW:0]    hi_ff, hi_in;
   logic [BW-1:0]          lo_ff, lo_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic                   last;
   logic signed [DigW:0]   digit_s;
   logic signed [SumW-1:0] part;
   logic signed [SumW-1:0] sum;

   logic signed [ExtW-1:0]       prod_ext;
   logic [TopW-1:0]              top_bits;
   logic                         sat;
   logic signed [WORD_WIDTH-1:0] max_val;
   logic signed [WORD_WIDTH-1:0] min_val;

   // The multiplier digits are unsigned except the top one, which carries
   // the sign of the two's complement operand.
   always_comb begin
      last    = (cnt_ff == CntW'(NumDig - 1));
      digit_s = last ? {b_ff[DigW-1], b_ff[DigW-1:0]} : {1'b0, b_ff[DigW-1:0]};
      part    = a_ff * digit_s;
      sum     = SumW'(hi_ff) + part;
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = BW'(op_b);
         hi_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[SumW-1:DigW];
         lo_in  = {sum[DigW-1:0], lo_ff[BW-1:DigW]};
         b_in   = b_ff >> DigW;
         cnt_in = cnt_ff + CntW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Taking bits above the fraction is a shift that rounds toward minus
   // infinity; the result saturates when the word's sign bit and the bits above it are not all equal.
   always_comb begin
      prod_ext = ExtW'($signed({hi_ff, lo_ff}));
      top_bits = prod_ext[ExtW-1:FRAC_BITS+WORD_WIDTH-1];
      sat      = !((&top_bits) || !(|top_bits));
      max_val  = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      min_val  = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      if (sat) begin
         result = top_bits[TopW-1] ? min_val : max_val;
      end else begin
         result = prod_ext[FRAC_BITS +: WORD_WIDTH];
      end
      status.busy = busy_ff;
      status.done = done_ff;
      status.sat  = sat;
   end

endmodule

// ===== src/lep_csr.sv =====
// Configuration register file of the particle push block: time step,
// charge-to-mass ratio and start state. Depends on lep_pkg and lep_csr_if.
module lep_csr #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH,
   parameter int FRAC_BITS  = lep_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   lep_csr_if.sink                                csr_chan,
   output logic [lep_pkg::TIME_STEP_WIDTH-1:0]    time_step,
   output logic signed [WORD_WIDTH-1:0]           charge_to_mass,
   output logic signed [WORD_WIDTH-1:0]           start_pos [3],
   output logic signed [WORD_WIDTH-1:0]           start_vel [3]
);

   localparam int DtW = lep_pkg::TIME_STEP_WIDTH;

   localparam logic [DtW-1:0] ResetDt =
      DtW'(lep_pkg::csr_reset_value(lep_pkg::CSR_TIME_STEP, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetQm =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_CHARGE_TO_MASS, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetX =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_X, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetY =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_Y, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetZ =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_Z, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVx =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VX, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVy =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VY, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVz =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VZ, FRAC_BITS));

   logic [DtW-1:0]               dt_ff, dt_in;
   logic signed [WORD_WIDTH-1:0] qm_ff, qm_in;
   logic signed [WORD_WIDTH-1:0] spos_ff [3];
   logic signed [WORD_WIDTH-1:0] spos_in [3];
   logic signed [WORD_WIDTH-1:0] svel_ff [3];
   logic signed [WORD_WIDTH-1:0] svel_in [3];

   assign csr_chan.ready = 1'b1;

   always_comb begin
      dt_in   = dt_ff;
      qm_in   = qm_ff;
      spos_in = spos_ff;
      svel_in = svel_ff;
      if (csr_chan.valid) begin
         case (lep_pkg::csr_index_type'(csr_chan.index))
            lep_pkg::CSR_TIME_STEP:      dt_in = csr_chan.data[DtW-1:0];
            lep_pkg::CSR_CHARGE_TO_MASS: qm_in = csr_chan.data;
            lep_pkg::CSR_START_X:        spos_in[0] = csr_chan.data;
            lep_pkg::CSR_START_Y:        spos_in[1] = csr_chan.data;
            lep_pkg::CSR_START_Z:        spos_in[2] = csr_chan.data;
            lep_pkg::CSR_START_VX:       svel_in[0] = csr_chan.data;
            lep_pkg::CSR_START_VY:       svel_in[1] = csr_chan.data;
            lep_pkg::CSR_START_VZ:       svel_in[2] = csr_chan.data;
            default:                     dt_in = dt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff      <= ResetDt;
         qm_ff      <= ResetQm;
         spos_ff[0] <= ResetX;
         spos_ff[1] <= ResetY;
         spos_ff[2] <= ResetZ;
         svel_ff[0] <= ResetVx;
         svel_ff[1] <= ResetVy;
         svel_ff[2] <= ResetVz;
      end else begin
         dt_ff   <= dt_in;
         qm_ff   <= qm_in;
         spos_ff <= spos_in;
         svel_ff <= svel_in;
      end
   end

   assign time_step      = dt_ff;
   assign charge_to_mass = qm_ff;
   assign start_pos      = spos_ff;
   assign start_vel      = svel_ff;

endmodule

// ===== src/lorentz_euler_particle_step.sv =====
// Top level of the particle push: step sequencer, particle state and the
// response register. Depends on lep_pkg, lep_if, lep_csr, lep_serial_mul and assert_macros.svh.
//
// Use: each transfer on req_chan carries the local magnetic field and a
// restart flag. Restart reloads position and velocity from the start
// registers before the step. The block answers each request with one
// transfer on rsp_chan holding the position and velocity before the step
// and a flag that is set when any product, sum or difference of the step
// saturated. csr_chan writes the configuration registers; the user is to
// write them only while the block is idle, which the block does not enforce.
// It is always ready. A new time step or charge-to-mass ratio acts from the
// next step on, and new start values act on the next restart.
// Timing: the fifteen products of a step run one after another on a single
// digit-serial multiplier that consumes 8 multiplier bits per cycle. A request
// is taken only once the step before it has finished: the next request is
// taken in the cycle after a response is loaded, while that response still
// waits. A stalled receiver holds the finished step in its final state until
// the response register frees up.
// Reset: synchronous; registers and particle state return to their reset
// values, and no response is pending.
`include "assert_macros.svh"

module lorentz_euler_particle_step #(
   parameter int WORD_WIDTH = lep_pkg::DEFAULT_WORD_WIDTH,
   parameter int FRAC_BITS  = lep_pkg::DEFAULT_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lep_req_if.sink   req_chan,
   lep_rsp_if.source rsp_chan,
   lep_csr_if.sink   csr_chan
);

   localparam int StepW = lep_pkg::STEP_WIDTH;

   localparam logic [WORD_WIDTH-1:0] ResetX =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_X, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetY =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_Y, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetZ =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_Z, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVx =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VX, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVy =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VY, FRAC_BITS));
   localparam logic [WORD_WIDTH-1:0] ResetVz =
      WORD_WIDTH'(lep_pkg::csr_reset_value(lep_pkg::CSR_START_VZ, FRAC_BITS));

   // Configuration.
   logic [lep_pkg::TIME_STEP_WIDTH-1:0] time_step;
   logic signed [WORD_WIDTH-1:0]        charge_to_mass;
   logic signed [WORD_WIDTH-1:0]        start_pos [3];
   logic signed [WORD_WIDTH-1:0]        start_vel [3];

   // Sequencer.
   lep_pkg::lep_state_type state_ff, state_in;
   logic [StepW-1:0]       step_ff, step_in;
   lep_pkg::uop_type       uop;
   logic                   req_accept;
   logic                   mul_start;
   logic                   post_en;
   logic                   out_free;
   logic                   commit;
   logic                   last_step;

   // Particle state and scratch values.
   logic signed [WORD_WIDTH-1:0] pos_ff   [3];
   logic signed [WORD_WIDTH-1:0] pos_in   [3];
   logic signed [WORD_WIDTH-1:0] vel_ff   [3];
   logic signed [WORD_WIDTH-1:0] vel_in   [3];
   logic signed [WORD_WIDTH-1:0] npos_ff  [3];
   logic signed [WORD_WIDTH-1:0] npos_in  [3];
   logic signed [WORD_WIDTH-1:0] acc_ff   [3];
   logic signed [WORD_WIDTH-1:0] acc_in   [3];
   logic signed [WORD_WIDTH-1:0] field_ff [3];
   logic signed [WORD_WIDTH-1:0] field_in [3];
   logic signed [WORD_WIDTH-1:0] tmp_ff, tmp_in;
   logic                         sat_ff, sat_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_WIDTH-1:0] out_pos_ff [3];
   logic signed [WORD_WIDTH-1:0] out_pos_in [3];
   logic signed [WORD_WIDTH-1:0] out_vel_ff [3];
   logic signed [WORD_WIDTH-1:0] out_vel_in [3];
   logic                         out_sat_ff, out_sat_in;

   // Multiplier and post-adder.
   logic signed [WORD_WIDTH:0]   op_a;
   logic signed [WORD_WIDTH:0]   op_b;
   logic signed [WORD_WIDTH-1:0] mul_result;
   lep_pkg::mul_status_type      mul_stat;
   logic signed [WORD_WIDTH-1:0] add_lhs;
   logic signed [WORD_WIDTH-1:0] add_rhs;
   logic                         add_sub;
   logic signed [WORD_WIDTH:0]   add_wide;
   logic                         add_ovf;
   logic signed [WORD_WIDTH-1:0] add_result;
   logic                         add_used;

   lep_csr #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_chan       (csr_chan),
      .time_step      (time_step),
      .charge_to_mass (charge_to_mass),
      .start_pos      (start_pos),
      .start_vel      (start_vel)
   );

   lep_serial_mul #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mul_result),
      .status (mul_stat)
   );

   assign uop       = lep_pkg::decode_step(step_ff);
   assign last_step = (step_ff == lep_pkg::LAST_STEP);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lep_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = lep_pkg::ST_ISSUE;
         end
         lep_pkg::ST_ISSUE: begin
            state_in = lep_pkg::ST_WAIT;
         end
         lep_pkg::ST_WAIT: begin
            if (mul_stat.done) begin
               state_in = last_step ? lep_pkg::ST_FINISH : lep_pkg::ST_ISSUE;
            end
         end
         lep_pkg::ST_FINISH: begin
            if (out_free) state_in = lep_pkg::ST_IDLE;
         end
         default: state_in = lep_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      mul_start      = 1'b0;
      post_en        = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         lep_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         lep_pkg::ST_ISSUE:  mul_start = 1'b1;
         lep_pkg::ST_WAIT:   post_en = mul_stat.done;
         lep_pkg::ST_FINISH: commit = out_free;
         default:            req_chan.ready = 1'b0;
      endcase
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (uop.a_src)
         lep_pkg::A_VEL: op_a = (WORD_WIDTH+1)'(vel_ff[uop.a_idx]);
         lep_pkg::A_QM:  op_a = (WORD_WIDTH+1)'(charge_to_mass);
         lep_pkg::A_ACC: op_a = (WORD_WIDTH+1)'(acc_ff[uop.a_idx]);
         default:        op_a = '0;
      endcase
      case (uop.b_src)
         lep_pkg::B_FIELD: op_b = (WORD_WIDTH+1)'(field_ff[uop.b_idx]);
         lep_pkg::B_ACC:   op_b = (WORD_WIDTH+1)'(acc_ff[uop.b_idx]);
         lep_pkg::B_DT:    op_b = (WORD_WIDTH+1)'(time_step);
         default:          op_b = '0;
      endcase
   end

   // Saturating add or subtract applied to the product of the step.
   always_comb begin
      add_sub  = 1'b0;
      add_used = 1'b1;
      case (uop.post)
         lep_pkg::POST_SUB_ACC: begin
            add_lhs = tmp_ff;
            add_sub = 1'b1;
         end
         lep_pkg::POST_ADD_POS: add_lhs = pos_ff[uop.dst];
         lep_pkg::POST_ADD_VEL: add_lhs = vel_ff[uop.dst];
         default: begin
            add_lhs  = '0;
            add_used = 1'b0;
         end
      endcase
      add_rhs  = add_sub ? ~mul_result : mul_result;
      add_wide = (WORD_WIDTH+1)'(add_lhs) + (WORD_WIDTH+1)'(add_rhs)
                 + (WORD_WIDTH+1)'(add_sub);
      add_ovf  = add_wide[WORD_WIDTH] != add_wide[WORD_WIDTH-1];
      if (add_ovf) begin
         add_result = add_wide[WORD_WIDTH] ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                                           : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else begin
         add_result = add_wide[WORD_WIDTH-1:0];
      end
   end

   // Datapath next values.
   always_comb begin
      step_in      = step_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      npos_in      = npos_ff;
      acc_in       = acc_ff;
      field_in     = field_ff;
      tmp_in       = tmp_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      out_pos_in   = out_pos_ff;
      out_vel_in   = out_vel_ff;
      out_sat_in   = out_sat_ff;

      if (req_accept) begin
         if (req_chan.restart) begin
            pos_in = start_pos;
            vel_in = start_vel;
         end
         field_in[0] = req_chan.field_x;
         field_in[1] = req_chan.field_y;
         field_in[2] = req_chan.field_z;
         sat_in      = 1'b0;
         step_in     = '0;
      end

      if (post_en) begin
         sat_in = sat_ff || mul_stat.sat || (add_used && add_ovf);
         case (uop.post)
            lep_pkg::POST_TMP:     tmp_in = mul_result;
            lep_pkg::POST_SUB_ACC: acc_in[uop.dst] = add_result;
            lep_pkg::POST_MOV_ACC: acc_in[uop.dst] = mul_result;
            lep_pkg::POST_ADD_POS: npos_in[uop.dst] = add_result;
            lep_pkg::POST_ADD_VEL: acc_in[uop.dst] = add_result;
            default:               tmp_in = tmp_ff;
         endcase
         if (!last_step) step_in = step_ff + StepW'(1);
      end

      // The old state goes out while the new state is written back.
      if (commit) begin
         out_pos_in   = pos_ff;
         out_vel_in   = vel_ff;
         out_sat_in   = sat_ff;
         pos_in       = npos_ff;
         vel_in       = acc_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      npos_ff    <= npos_in;
      acc_ff     <= acc_in;
      field_ff   <= field_in;
      tmp_ff     <= tmp_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_sat_ff <= out_sat_in;
      if (reset) begin
         state_ff     <= lep_pkg::ST_IDLE;
         step_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff[0]    <= ResetX;
         pos_ff[1]    <= ResetY;
         pos_ff[2]    <= ResetZ;
         vel_ff[0]    <= ResetVx;
         vel_ff[1]    <= ResetVy;
         vel_ff[2]    <= ResetVz;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pos_x     = out_pos_ff[0];
   assign rsp_chan.pos_y     = out_pos_ff[1];
   assign rsp_chan.pos_z     = out_pos_ff[2];
   assign rsp_chan.vel_x     = out_vel_ff[0];
   assign rsp_chan.vel_y     = out_vel_ff[1];
   assign rsp_chan.vel_z     = out_vel_ff[2];
   assign rsp_chan.saturated = out_sat_ff;

   // A product only completes while the sequencer waits for it.
   `LEP_ASSERT_SAME(a_done_in_wait, clock, reset, mul_stat.done,
      state_ff == lep_pkg::ST_WAIT, "multiplier finished outside the wait state")

   // Issuing a step always sets the multiplier running.
   `LEP_ASSERT_NEXT(a_issue_starts_mul, clock, reset, state_ff == lep_pkg::ST_ISSUE,
      mul_stat.busy, "issued step did not start the multiplier")

   // A request transfer begins its step sequence at the first product.
   `LEP_ASSERT_NEXT(a_accept_restarts_seq, clock, reset, req_accept,
      (state_ff == lep_pkg::ST_ISSUE) && (step_ff == '0),
      "request transfer did not start a new step sequence")

endmodule

// ===== bench/lorentz_euler_particle_step_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lorentz_euler_particle_step: drives field vectors and register
// writes, predicts every response in fixed point and compares it field by field.
// Depends on lep_pkg, the channel interfaces in lep_if and the block itself.
module lorentz_euler_particle_step_tb;

   localparam int WORD_WIDTH      = lep_pkg::DEFAULT_WORD_WIDTH;
   localparam int FRAC_BITS       = lep_pkg::DEFAULT_FRAC_BITS;
   localparam int TIME_STEP_WIDTH = lep_pkg::TIME_STEP_WIDTH;
   localparam int NUM_REGS        = 8;
   localparam int STEP_CYCLES     = 122;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int ORBIT_PHASES    = 10;
   localparam int ORBIT_STEPS     = 120;
   localparam int STREAM_STEPS    = 150;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [127:0]          wide_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam word_type FIX_ONE  = word_type'(1) <<< FRAC_BITS;

   typedef struct packed {
      word_type pos_x, pos_y, pos_z;
      word_type vel_x, vel_y, vel_z;
      logic     saturated;
   } particle_report_type;

   logic clock = 1'b0;
   logic reset;

   lep_req_if req_if ();
   lep_rsp_if rsp_if ();
   lep_csr_if csr_if ();

   lorentz_euler_particle_step dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #4 clock = ~clock;

   // Shadow copy of the registers and of the particle the block is pushing.
   logic [WORD_WIDTH-1:0] shadow_regs [NUM_REGS];
   word_type              part_pos [3];
   word_type              part_vel [3];
   bit                    step_sat;

   particle_report_type pending_reports [$];

   int error_count;
   int items_sent;
   int restarts_sent;
   int reports_seen;
   int saturated_seen;
   int settings_loaded;
   int stall_left;
   int idle_cycles;
   bit idling_on;

   function automatic word_type fit_word(wide_type v);
      if (v > wide_type'(WORD_MAX)) begin
         step_sat = 1'b1;
         return WORD_MAX;
      end
      if (v < wide_type'(WORD_MIN)) begin
         step_sat = 1'b1;
         return WORD_MIN;
      end
      return word_type'(v);
   endfunction

   // The arithmetic shift floors the product toward minus infinity.
   function automatic word_type q_mul(wide_type a, wide_type b);
      return fit_word((a * b) >>> FRAC_BITS);
   endfunction

   function automatic word_type q_add(wide_type a, wide_type b);
      return fit_word(a + b);
   endfunction

   function automatic word_type q_sub(wide_type a, wide_type b);
      return fit_word(a - b);
   endfunction

   function automatic void reload_from_start();
      for (int i = 0; i < 3; i++) begin
         part_pos[i] = word_type'(shadow_regs[lep_pkg::CSR_START_X + i]);
         part_vel[i] = word_type'(shadow_regs[lep_pkg::CSR_START_VX + i]);
      end
   endfunction

   function automatic void restore_defaults();
      shadow_regs[lep_pkg::CSR_TIME_STEP]      = WORD_WIDTH'(16777);  // one thousandth
      shadow_regs[lep_pkg::CSR_CHARGE_TO_MASS] = FIX_ONE;
      shadow_regs[lep_pkg::CSR_START_X]        = '0;
      shadow_regs[lep_pkg::CSR_START_Y]        = FIX_ONE;
      shadow_regs[lep_pkg::CSR_START_Z]        = '0;
      shadow_regs[lep_pkg::CSR_START_VX]       = FIX_ONE;
      shadow_regs[lep_pkg::CSR_START_VY]       = '0;
      shadow_regs[lep_pkg::CSR_START_VZ]       = word_type'(10) <<< FRAC_BITS;
      reload_from_start();
   endfunction

   // One Euler step: report the state before the step, then update it.
   function automatic particle_report_type advance_particle(logic restart, word_type bx,
                                                            word_type by, word_type bz);
      particle_report_type rep;
      word_type            acc [3];
      wide_type            dt;
      word_type            qm;
      step_sat = 1'b0;
      if (restart) reload_from_start();
      rep.pos_x = part_pos[0];
      rep.pos_y = part_pos[1];
      rep.pos_z = part_pos[2];
      rep.vel_x = part_vel[0];
      rep.vel_y = part_vel[1];
      rep.vel_z = part_vel[2];
      dt = wide_type'(shadow_regs[lep_pkg::CSR_TIME_STEP][TIME_STEP_WIDTH-1:0]);
      qm = word_type'(shadow_regs[lep_pkg::CSR_CHARGE_TO_MASS]);
      acc[0] = q_mul(qm, q_sub(q_mul(part_vel[1], bz), q_mul(part_vel[2], by)));
      acc[1] = q_mul(qm, q_sub(q_mul(part_vel[2], bx), q_mul(part_vel[0], bz)));
      acc[2] = q_mul(qm, q_sub(q_mul(part_vel[0], by), q_mul(part_vel[1], bx)));
      for (int i = 0; i < 3; i++) part_pos[i] = q_add(part_pos[i], q_mul(part_vel[i], dt));
      for (int i = 0; i < 3; i++) part_vel[i] = q_add(part_vel[i], q_mul(acc[i], dt));
      rep.saturated = step_sat;
      return rep;
   endfunction

   function automatic word_type random_word();
      return word_type'({$urandom, $urandom});
   endfunction

   function automatic word_type pick_extreme();
      case ($urandom_range(0, 4))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return word_type'(0);
         3:       return word_type'(-1);
         default: return word_type'(1);
      endcase
   endfunction

   // Mostly fields of physical size, with full-range values and extremes mixed in.
   function automatic word_type pick_field();
      case ($urandom_range(0, 15))
         0:       return pick_extreme();
         1, 2:    return random_word();
         default: return random_word() >>> $urandom_range(11, 20);
      endcase
   endfunction

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   task automatic compare_field(string name, word_type want, word_type got);
      if (got !== want)
         note_failure($sformatf("%s mismatch at %0t: expected %0d, got %0d",
                                name, $time, want, got));
   endtask

   task automatic check_report();
      particle_report_type want;
      reports_seen++;
      if (rsp_if.saturated === 1'b1) saturated_seen++;
      if (pending_reports.size() == 0) begin
         note_failure($sformatf("response at %0t with no step pending: pos %0d %0d %0d",
                                $time, rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z));
         return;
      end
      want = pending_reports.pop_front();
      compare_field("pos_x", want.pos_x, rsp_if.pos_x);
      compare_field("pos_y", want.pos_y, rsp_if.pos_y);
      compare_field("pos_z", want.pos_z, rsp_if.pos_z);
      compare_field("vel_x", want.vel_x, rsp_if.vel_x);
      compare_field("vel_y", want.vel_y, rsp_if.vel_y);
      compare_field("vel_z", want.vel_z, rsp_if.vel_z);
      compare_field("saturated", word_type'(want.saturated), word_type'(rsp_if.saturated));
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_report();
   end

   // Receiver stalls start at random while idling is on and last a randomly drawn length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid & req_if.ready) === 1'b1 || (rsp_if.valid & rsp_if.ready) === 1'b1 ||
          (csr_if.valid & csr_if.ready) === 1'b1)
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("lorentz_euler_particle_step test failed");
         $finish;
      end
   end

   // Leaves valid high after the transfer so that the next item can follow at once.
   task automatic send_step(logic restart, word_type bx, word_type by, word_type bz);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      req_if.field_x <= bx;
      req_if.field_y <= by;
      req_if.field_z <= bz;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_reports.push_back(advance_particle(restart, bx, by, bz));
      items_sent++;
      if (restart) restarts_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(lep_pkg::csr_index_type idx, logic [WORD_WIDTH-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (idx == lep_pkg::CSR_TIME_STEP)
         shadow_regs[idx] = {{(WORD_WIDTH-TIME_STEP_WIDTH){1'b0}},
                             value[TIME_STEP_WIDTH-1:0]};
      else
         shadow_regs[idx] = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // The upper data bits of the time step write are junk that the block must drop.
   task automatic load_settings(logic [TIME_STEP_WIDTH-1:0] dt, word_type qm, word_type sx,
                                word_type sy, word_type sz, word_type vx, word_type vy,
                                word_type vz);
      logic [WORD_WIDTH-1:0] dt_word;
      settle();
      dt_word = WORD_WIDTH'({$urandom, $urandom});
      dt_word[TIME_STEP_WIDTH-1:0] = dt;
      write_register(lep_pkg::CSR_TIME_STEP, dt_word);
      write_register(lep_pkg::CSR_CHARGE_TO_MASS, qm);
      write_register(lep_pkg::CSR_START_X, sx);
      write_register(lep_pkg::CSR_START_Y, sy);
      write_register(lep_pkg::CSR_START_Z, sz);
      write_register(lep_pkg::CSR_START_VX, vx);
      write_register(lep_pkg::CSR_START_VY, vy);
      write_register(lep_pkg::CSR_START_VZ, vz);
      settings_loaded++;
   endtask

   task automatic random_settings();
      logic [TIME_STEP_WIDTH-1:0] dt;
      word_type                   qm;
      word_type                   start [6];
      case ($urandom_range(0, 7))
         0:       dt = '1;
         1:       dt = '0;
         2:       dt = TIME_STEP_WIDTH'($urandom);
         default: dt = TIME_STEP_WIDTH'($urandom >> $urandom_range(8, 20));
      endcase
      qm = ($urandom_range(0, 5) == 0) ? random_word() : random_word() >>> $urandom_range(10, 18);
      foreach (start[i])
         start[i] = ($urandom_range(0, 7) == 0) ? random_word()
                                                : random_word() >>> $urandom_range(4, 18);
      load_settings(dt, qm, start[0], start[1], start[2], start[3], start[4], start[5]);
   endtask

   task automatic test_reset_state();
      send_step(1'b0, '0, '0, '0);
      send_step(1'b0, '0, '0, FIX_ONE);
      send_step(1'b1, '0, '0, '0);
   endtask

   // Saturating products and differences, then a clean step whose flag must be clear.
   task automatic test_field_extremes();
      send_step(1'b1, WORD_MAX, WORD_MAX, WORD_MAX);
      send_step(1'b0, WORD_MIN, WORD_MIN, WORD_MIN);
      send_step(1'b1, word_type'(-1), word_type'(-1), word_type'(-1));
      send_step(1'b1, WORD_MIN, '0, WORD_MAX);
      send_step(1'b1, '0, '0, '0);
      send_step(1'b0, word_type'(1), word_type'(-1), word_type'(1));
   endtask

   // New start values only take effect at the next restart.
   task automatic test_pending_restart();
      load_settings(24'h800000, word_type'(-2) <<< FRAC_BITS,
                    word_type'(-7) <<< (FRAC_BITS - 1), word_type'(9) <<< (FRAC_BITS - 2),
                    word_type'(-1), word_type'(-3) <<< (FRAC_BITS - 1),
                    word_type'(3) <<< (FRAC_BITS - 2), word_type'(-1) <<< (FRAC_BITS - 3));
      send_step(1'b0, FIX_ONE, '0, '0);
      send_step(1'b0, '0, FIX_ONE, '0);
      send_step(1'b1, '0, '0, FIX_ONE);
      send_step(1'b0, word_type'(-3) <<< FRAC_BITS, FIX_ONE, word_type'(-5));
      send_step(1'b0, '0, word_type'(-1) <<< (FRAC_BITS + 2), FIX_ONE);
   endtask

   task automatic test_extreme_settings();
      load_settings('1, WORD_MAX, WORD_MAX, WORD_MIN, '0, WORD_MAX, WORD_MIN, FIX_ONE);
      send_step(1'b1, FIX_ONE, -FIX_ONE, FIX_ONE);
      send_step(1'b0, pick_field(), pick_field(), pick_field());
      send_step(1'b0, pick_field(), pick_field(), pick_field());
      load_settings('0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_step(1'b1, FIX_ONE, FIX_ONE, FIX_ONE);
      send_step(1'b0, WORD_MIN, WORD_MAX, word_type'(-1));
      send_step(1'b0, '0, '0, '0);
      // Tiny negative values whose products floor to minus one.
      load_settings(24'd1, word_type'(-1), word_type'(-2), word_type'(3), '0, word_type'(-3),
                    FIX_ONE, word_type'(-1) <<< FRAC_BITS);
      send_step(1'b1, word_type'(-1) <<< FRAC_BITS, word_type'(1), FIX_ONE);
      send_step(1'b0, word_type'(-1), word_type'(-1), word_type'(-1));
   endtask

   task automatic test_random_orbits();
      for (int phase = 0; phase < ORBIT_PHASES; phase++) begin
         idling_on = ($urandom_range(0, 3) != 0);
         random_settings();
         for (int n = 0; n < ORBIT_STEPS; n++)
            send_step(n == 0 || $urandom_range(0, 31) == 0,
                      pick_field(), pick_field(), pick_field());
      end
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      random_settings();
      for (int n = 0; n < STREAM_STEPS; n++)
         send_step(n == 0 || $urandom_range(0, 31) == 0,
                   pick_field(), pick_field(), pick_field());
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      req_if.field_x = '0;
      req_if.field_y = '0;
      req_if.field_z = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = lep_pkg::CSR_TIME_STEP;
      csr_if.data    = '0;
      idling_on      = 1'b1;
      stall_left     = 0;
      idle_cycles    = 0;
      restore_defaults();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_pending_restart();
      test_extreme_settings();
      test_random_orbits();
      test_steady_stream();

      settle();
      repeat (STEP_CYCLES + 8) @(posedge clock);
      $display("Pushed %0d particle steps (%0d restarts) under %0d register settings.",
               items_sent, restarts_sent, settings_loaded);
      $display("Checked %0d responses, %0d flagged as saturated; %0d failures.",
               reports_seen, saturated_seen, error_count);
      if (error_count == 0 && pending_reports.size() == 0)
         $display("lorentz_euler_particle_step test passed");
      else
         $display("lorentz_euler_particle_step test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/lep_pkg.sv
src/lep_if.sv
src/lep_serial_mul.sv
src/lep_csr.sv
src/lorentz_euler_particle_step.sv
bench/lorentz_euler_particle_step_tb.sv
